// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, disabled in reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked assertion, also checked in reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: hdl/bni_pkg.sv
`default_nettype none
package bni_pkg;
	localparam int CHANNELS_DEF = 256;
	localparam logic [31:0] STAT_MULT_RST = 32'd65536;
	localparam logic [31:0] EPSILON_RST = 32'd42950;
	localparam logic [31:0] FACTOR_MAX = 32'hFFFF_FFFF;
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;
	localparam logic CFG_STAT_MULT = 1'b0;
	localparam logic CFG_EPSILON = 1'b1;
	localparam int DIV_STEPS = 65;
	localparam int SQRT_STEPS = 32;

	typedef struct packed {
		logic ld;
		logic mul_off;
		logic mul_var;
		logic rad;
		logic div_step;
		logic sq_init;
		logic sq_step;
		logic wr;
		logic rd;
		logic smul;
		logic rnd;
	} cmd_t;

	typedef struct packed {
		logic is_sample;
	} stat_t;

	// round q32.32 magnitude to q16.16, saturate with sign; msb is clip
	function automatic logic [32:0] round_sat(input logic [63:0] mag, input logic neg);
		logic [64:0] sum;
		logic [48:0] r;
		logic [31:0] rl;
		sum = {1'b0, mag} + 65'd32768;
		r = sum[64:16];
		rl = r[31:0];
		if (!neg) begin
			if (r > 49'h0_7FFF_FFFF) round_sat = {1'b1, 32'h7FFF_FFFF};
			else round_sat = {1'b0, rl};
		end else begin
			if (r > 49'h0_8000_0000) round_sat = {1'b1, 32'h8000_0000};
			else round_sat = {1'b0, 32'd0 - rl};
		end
	endfunction
endpackage
`default_nettype wire

// File: hdl/bni_ram.sv
`default_nettype none
module bni_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: hdl/bni_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module bni_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	input  wire bni_pkg::stat_t stat,
	output bni_pkg::cmd_t    cmd
);
	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_LM1  = 12'b0000_0000_0010,
		S_LM2  = 12'b0000_0000_0100,
		S_LRAD = 12'b0000_0000_1000,
		S_DIV  = 12'b0000_0001_0000,
		S_SQI  = 12'b0000_0010_0000,
		S_SQ   = 12'b0000_0100_0000,
		S_WR   = 12'b0000_1000_0000,
		S_RD   = 12'b0001_0000_0000,
		S_SMUL = 12'b0010_0000_0000,
		S_RND  = 12'b0100_0000_0000,
		S_OUT  = 12'b1000_0000_0000
	} state_t;

	localparam int DIV_STEPS_M1 = bni_pkg::DIV_STEPS - 1;
	localparam int SQRT_STEPS_M1 = bni_pkg::SQRT_STEPS - 1;

	state_t state_q, state_d;
	logic [6:0] cnt_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.ld = 1'b1;
					state_d = S_LM1;
				end
			end
			S_LM1: begin
				if (stat.is_sample) state_d = S_RD;
				else begin
					cmd.mul_off = 1'b1;
					state_d = S_LM2;
				end
			end
			S_LM2: begin
				cmd.mul_var = 1'b1;
				state_d = S_LRAD;
			end
			S_LRAD: begin
				cmd.rad = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == 7'(DIV_STEPS_M1)) state_d = S_SQI;
			end
			S_SQI: begin
				cmd.sq_init = 1'b1;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.sq_step = 1'b1;
				if (cnt_q == 7'(SQRT_STEPS_M1)) state_d = S_WR;
			end
			S_WR: begin
				cmd.wr = 1'b1;
				state_d = S_IDLE;
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_SMUL;
			end
			S_SMUL: begin
				cmd.smul = 1'b1;
				state_d = S_RND;
			end
			S_RND: begin
				cmd.rnd = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + 7'd1;
		end
	end

	`ASSERT_ALWAYS(a_ready_not_valid, clk, !arst_n || !(s_tready && m_tvalid), "ready while result pending")
	`ASSERT_CLK(a_wr_load_only, clk, arst_n, cmd.wr |-> !stat.is_sample, "ram write on sample")
	`ASSERT_CLK(a_div_len, clk, arst_n, cmd.sq_init |-> $past(cmd.div_step), "sqrt started early")
	`ASSERT_CLK(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped")
endmodule
`default_nettype wire

// File: hdl/bni_datapath.sv
`default_nettype none
module bni_datapath #(
	parameter int CHANNELS = bni_pkg::CHANNELS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bni_pkg::cmd_t cmd,
	output bni_pkg::stat_t     stat,
	input  wire logic [103:0]  in_data,
	input  wire logic          in_user,
	input  wire logic [31:0]   stat_mult,
	input  wire logic [31:0]   eps,
	output logic [39:0]        out_data,
	output logic               out_user
);
	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic        sample_q, valid_q;
	logic [7:0]  ch_q;
	logic [31:0] mean_q, var_q, x_q;
	logic [63:0] offprod_q, varprod_q, rad_q, rem_q, quo_q, sqv_q, prod_q;
	logic [64:0] dvd_q;
	logic [31:0] off_q, root_q, out_val_q;
	logic [33:0] srem_q;
	logic        neg_q, fmax_q, out_sat_q;
	logic [63:0] ram_rdata;
	logic [11:0] ch_ext;
	logic [31:0] mean_mag;
	logic [64:0] rad_sum, div_t;
	logic [35:0] sq_t, sq_trial;
	logic [32:0] off_rs, res_rs;
	logic [32:0] diff, dmag;
	logic [31:0] fac_wr, ram_off, ram_fac;

	assign ch_ext = {4'd0, ch_q};
	assign stat.is_sample = sample_q;
	assign mean_mag = mean_q[31] ? 32'd0 - mean_q : mean_q;
	assign rad_sum = {1'b0, varprod_q} + {33'd0, eps};
	assign off_rs = bni_pkg::round_sat(offprod_q, mean_q[31]);
	assign div_t = {rem_q, dvd_q[64]};
	assign sq_t = {srem_q, sqv_q[63:62]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign fac_wr = (rad_q <= 64'd1) ? bni_pkg::FACTOR_MAX : root_q;
	assign ram_off = ram_rdata[31:0];
	assign ram_fac = ram_rdata[63:32];
	assign diff = {x_q[31], x_q} - {ram_off[31], ram_off};
	assign dmag = diff[32] ? 33'd0 - diff : diff;
	assign res_rs = bni_pkg::round_sat(prod_q, neg_q);

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			sample_q <= in_user;
			ch_q <= in_data[7:0];
			mean_q <= in_data[39:8];
			var_q <= in_data[71:40];
			x_q <= in_data[103:72];
			valid_q <= {24'd0, in_data[7:0]} < 32'(CHANNELS);
		end
		if (cmd.mul_off) offprod_q <= {32'd0, mean_mag} * {32'd0, stat_mult};
		if (cmd.mul_var) varprod_q <= {32'd0, var_q} * {32'd0, stat_mult};
		if (cmd.rad) begin
			rad_q <= rad_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : rad_sum[63:0];
			off_q <= off_rs[31:0];
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= {1'b1, 64'd0};
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[63:0], 1'b0};
			if (div_t >= {1'b0, rad_q}) begin
				rem_q <= 64'(div_t - {1'b0, rad_q});
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= div_t[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
		if (cmd.sq_init) begin
			sqv_q <= quo_q;
			root_q <= '0;
			srem_q <= '0;
		end
		if (cmd.sq_step) begin
			sqv_q <= {sqv_q[61:0], 2'b00};
			if (sq_t >= sq_trial) begin
				srem_q <= 34'(sq_t - sq_trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				srem_q <= sq_t[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.smul) begin
			prod_q <= valid_q ? 64'({31'd0, dmag} * {32'd0, ram_fac}) : 64'd0;
			neg_q <= diff[32];
			fmax_q <= valid_q && (ram_fac == bni_pkg::FACTOR_MAX);
		end
		if (cmd.rnd) begin
			out_val_q <= res_rs[31:0];
			out_sat_q <= res_rs[32] | fmax_q;
		end
	end

	bni_ram #(.WIDTH(64), .DEPTH(CHANNELS)) u_ram (
		.clk   (clk),
		.we    (cmd.wr && valid_q && arst_n),
		.addr  (ch_ext[AW-1:0]),
		.wdata ({fac_wr, off_q}),
		.rdata (ram_rdata)
	);

	assign out_data = {ch_q, out_val_q};
	assign out_user = out_sat_q;
endmodule
`default_nettype wire

// File: hdl/batch_norm_inference_unit.sv
// channel  dir  tdata (low bit up)                                  tuser
// s_axis   in   channel 8, stat_mean 32, stat_var 32, sample_value 32  req_type
// m_axis   out  norm_value 32, out_channel 8                         saturated
// cfg      in   index 0 stat_multiplier, index 1 epsilon, 32-bit data
// a sample word: LM1, RD, SMUL, RND, then OUT until m_tready
// a load word: LM1, LM2, LRAD, 65-step divider, SQI, 32-step root, then WR
// one word in flight at a time; s_tready low until result taken or load written
// arst_n resets control and cfg only; channel memory is undefined until loaded
`default_nettype none
module batch_norm_inference_unit #(
	parameter int CHANNELS = bni_pkg::CHANNELS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata, // channel, stat_mean, stat_var, sample_value
	input  wire logic         s_tuser, // req_type
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [39:0]       m_tdata, // norm_value, out_channel
	output logic              m_tuser, // saturated
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_data
);
	logic [31:0] stat_mult_q, eps_q;
	bni_pkg::cmd_t cmd;
	bni_pkg::stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_mult_q <= bni_pkg::STAT_MULT_RST;
			eps_q <= bni_pkg::EPSILON_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bni_pkg::CFG_STAT_MULT: stat_mult_q <= cfg_data;
				bni_pkg::CFG_EPSILON: eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bni_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bni_datapath #(.CHANNELS(CHANNELS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.stat_mult (stat_mult_q),
		.eps       (eps_q),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);
endmodule
`default_nettype wire
